// File: design/srpf_pkg.sv
// Shared types and constants for the short-range pair force pipeline.
package srpf_pkg;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        CFG_CUTOFF = 2'd0,
        CFG_MIN    = 2'd1,
        CFG_MASS   = 2'd2
    } t_cfg_idx;

    localparam int W         = 32;   // Q16.16 word
    localparam int SQ_STAGES = 32;   // one root bit per stage
    localparam int DIV_BITS  = 31;   // quotient bits below the saturation point
    localparam int NUM_W     = 112;  // delta * force magnitude * 2^48
    localparam int DEN_W     = 128;  // r * r2 * mass

    // Per-axis delta magnitudes and signs
    typedef struct packed {
        logic         xneg;
        logic         yneg;
        logic [W-1:0] xm;
        logic [W-1:0] ym;
    } t_ax;

    // Item data riding alongside the square-root pipe
    typedef struct packed {
        logic         inr;
        t_ax          ax;
        logic [63:0]  r2;
    } t_side;

    // Tag riding alongside a divider
    typedef struct packed {
        logic inr;
        logic neg;
    } t_dtag;

endpackage

// File: design/srpf_isqrt.sv
// Pipelined floor square root of a 64-bit value, one root bit per stage.
module srpf_isqrt (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  srpf_pkg::t_side i_side,
    output logic            o_valid,
    output srpf_pkg::t_side o_side,
    output logic [31:0]     o_root
);
    import srpf_pkg::*;

    logic        w_v    [SQ_STAGES];
    t_side       w_side [SQ_STAGES];
    logic [65:0] w_rem  [SQ_STAGES];
    logic [31:0] w_root [SQ_STAGES];

    logic        r_v    [SQ_STAGES];
    t_side       r_side [SQ_STAGES];
    logic [65:0] r_rem  [SQ_STAGES];
    logic [31:0] r_root [SQ_STAGES];

    genvar j;
    generate
        for (j = 0; j < SQ_STAGES; j++) begin : g_stage
            localparam int B = SQ_STAGES - 1 - j;
            logic [65:0] cand;
            logic        fit;

            // stage inputs: port for the first, previous register otherwise
            if (j == 0) begin : g_first
                assign w_v[j]    = i_valid;
                assign w_side[j] = i_side;
                assign w_rem[j]  = {2'b00, i_side.r2};
                assign w_root[j] = '0;
            end else begin : g_next
                assign w_v[j]    = r_v[j-1];
                assign w_side[j] = r_side[j-1];
                assign w_rem[j]  = r_rem[j-1];
                assign w_root[j] = r_root[j-1];
            end

            // try setting root bit B: (root + 2^B)^2 - root^2
            assign cand = (66'(w_root[j]) << (B + 1)) + (66'd1 << (2 * B));
            assign fit  = (w_rem[j] >= cand);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[j] <= 1'b0;
                end else if (i_en) begin
                    r_v[j] <= w_v[j];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_side[j] <= w_side[j];
                    r_rem[j]  <= fit ? (w_rem[j] - cand) : w_rem[j];
                    r_root[j] <= fit ? (w_root[j] | (32'd1 << B)) : w_root[j];
                end
            end
        end
    endgenerate

    assign o_valid = r_v[SQ_STAGES-1];
    assign o_side  = r_side[SQ_STAGES-1];
    assign o_root  = r_root[SQ_STAGES-1];

endmodule

// File: design/srpf_div.sv
// Pipelined restoring divider: saturation flag, then one quotient bit per stage.
module srpf_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [srpf_pkg::NUM_W-1:0]    i_num,
    input  logic [srpf_pkg::DEN_W-1:0]    i_den,
    input  srpf_pkg::t_dtag               i_tag,
    output logic                          o_valid,
    output logic                          o_ovf,
    output logic [srpf_pkg::DIV_BITS-1:0] o_quo,
    output srpf_pkg::t_dtag               o_tag
);
    import srpf_pkg::*;

    localparam int NST = DIV_BITS + 1;

    logic                r_v   [NST];
    logic [NUM_W-1:0]    r_rem [NST];
    logic [DEN_W-1:0]    r_den [NST];
    logic [DIV_BITS-1:0] r_quo [NST];
    logic                r_ovf [NST];
    t_dtag               r_tag [NST];

    logic w_ovf;

    // quotient reaches 2^31: saturates either way
    assign w_ovf = (i_den[DEN_W-1:NUM_W-DIV_BITS] == '0) &&
                   (i_num >= (i_den[NUM_W-1:0] << DIV_BITS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_ovf[0] <= w_ovf;
            r_tag[0] <= i_tag;
        end
    end

    genvar k;
    generate
        for (k = 1; k < NST; k++) begin : g_stage
            localparam int I = DIV_BITS - k;
            logic             fit;
            logic [NUM_W-1:0] dsh;

            assign dsh = r_den[k-1][NUM_W-1:0] << I;
            assign fit = (r_den[k-1][DEN_W-1:NUM_W-I] == '0) && (r_rem[k-1] >= dsh);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (i_en) begin
                    r_v[k] <= r_v[k-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= fit ? (r_rem[k-1] - dsh) : r_rem[k-1];
                    r_den[k] <= r_den[k-1];
                    r_quo[k] <= fit ? (r_quo[k-1] | (DIV_BITS'(1) << I)) : r_quo[k-1];
                    r_ovf[k] <= r_ovf[k-1];
                    r_tag[k] <= r_tag[k-1];
                end
            end
        end
    endgenerate

    assign o_valid = r_v[NST-1];
    assign o_ovf   = r_ovf[NST-1];
    assign o_quo   = r_quo[NST-1];
    assign o_tag   = r_tag[NST-1];

endmodule

// File: design/short_range_pair_force.sv
// Short-range pair force: cutoff test, square root, force division, saturation.
// Throughput: one transaction per cycle while the skid register is empty; every stage of
// the square root and of both dividers is registered, so a new pair can enter each cycle.
// Synchronous active-low reset clears all valid bits and restores the configuration registers.
module short_range_pair_force (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration write port
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    // input stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [127:0] i_s_tdata,   // own_x, own_y, other_x, other_y
    // output stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [63:0]  o_m_tdata,   // accel_x, accel_y
    output logic         o_m_tuser    // in_range
);
    import srpf_pkg::*;

    // configuration registers
    logic [W-1:0]  r_cutoff, r_min, r_mass;
    logic [63:0]   r_cut2, r_min2;
    logic [W-1:0]  w_mass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff <= 32'd655;
            r_min    <= 32'd7;
            r_mass   <= 32'd655;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CUTOFF: r_cutoff <= i_cfg_data;
                CFG_MIN:    r_min    <= i_cfg_data;
                CFG_MASS:   r_mass   <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // squared thresholds are registered and follow the registers in the next cycle
    always_ff @(posedge i_clk) begin
        r_cut2 <= r_cutoff * r_cutoff;
        r_min2 <= r_min * r_min;
    end

    assign w_mass = (r_mass == '0) ? 32'd1 : r_mass;

    // pipeline advances unless the skid register is occupied
    logic r_skid_v, r_out_v;
    logic en;
    assign en         = !r_skid_v;
    assign o_s_tready = en;

    // stage a: deltas
    logic [W-1:0] w_ox, w_oy, w_nx, w_ny;
    assign w_ox = i_s_tdata[31:0];
    assign w_oy = i_s_tdata[63:32];
    assign w_nx = i_s_tdata[95:64];
    assign w_ny = i_s_tdata[127:96];

    logic        r_a_v, r_b_v, r_c_v, r_d_v;
    t_ax         r_a_ax, r_b_ax, r_c_ax;
    logic [63:0] r_b_x2, r_b_y2;
    logic [64:0] r_c_sum;
    t_side       r_d_side;

    // stage e..h control
    logic        r_e_v, r_f_v, r_g_v, r_h_v;
    logic        r_e_inr, r_f_inr, r_g_inr, r_h_inr;
    t_ax         r_e_ax, r_f_ax;
    logic        r_e_fneg, r_f_fneg, r_g_xn, r_g_yn, r_h_xn, r_h_yn;
    logic [W-1:0] r_e_fmag;
    logic [63:0] r_e_p0, r_e_p1, r_f_nx, r_f_ny;
    logic [95:0] r_f_t;
    logic [63:0] r_g_m0, r_g_m1, r_g_m2;
    logic [NUM_W-1:0] r_g_numx, r_g_numy, r_h_numx, r_h_numy;
    logic [DEN_W-1:0] r_h_den;

    logic        sq_v;
    t_side       sq_side;
    logic [31:0] sq_root;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
            r_h_v <= 1'b0;
        end else if (en) begin
            r_a_v <= i_s_tvalid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= sq_v;
            r_f_v <= r_e_v;
            r_g_v <= r_f_v;
            r_h_v <= r_g_v;
        end
    end

    // front stages: deltas, squares, sum, range test and clamp
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_ax.xneg <= (w_nx < w_ox);
            r_a_ax.yneg <= (w_ny < w_oy);
            r_a_ax.xm   <= (w_nx < w_ox) ? (w_ox - w_nx) : (w_nx - w_ox);
            r_a_ax.ym   <= (w_ny < w_oy) ? (w_oy - w_ny) : (w_ny - w_oy);

            r_b_ax <= r_a_ax;
            r_b_x2 <= r_a_ax.xm * r_a_ax.xm;
            r_b_y2 <= r_a_ax.ym * r_a_ax.ym;

            r_c_ax  <= r_b_ax;
            r_c_sum <= {1'b0, r_b_x2} + {1'b0, r_b_y2};

            r_d_side.ax  <= r_c_ax;
            r_d_side.inr <= !r_c_sum[64] && (r_c_sum[63:0] <= r_cut2);
            if (r_c_sum[63:0] < r_min2) begin
                r_d_side.r2 <= (r_min2 == '0) ? 64'd1 : r_min2;
            end else begin
                r_d_side.r2 <= (r_c_sum[63:0] == '0) ? 64'd1 : r_c_sum[63:0];
            end
        end
    end

    srpf_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_d_v),
        .i_side  (r_d_side),
        .o_valid (sq_v),
        .o_side  (sq_side),
        .o_root  (sq_root)
    );

    // back stages: force magnitude, numerators, denominator r * r2 * mass
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_inr  <= sq_side.inr;
            r_e_ax   <= sq_side.ax;
            r_e_fneg <= (sq_root < r_cutoff);
            r_e_fmag <= (sq_root < r_cutoff) ? (r_cutoff - sq_root) : (sq_root - r_cutoff);
            r_e_p0   <= sq_root * sq_side.r2[31:0];
            r_e_p1   <= sq_root * sq_side.r2[63:32];

            r_f_inr  <= r_e_inr;
            r_f_ax   <= r_e_ax;
            r_f_fneg <= r_e_fneg;
            r_f_nx   <= r_e_ax.xm * r_e_fmag;
            r_f_ny   <= r_e_ax.ym * r_e_fmag;
            r_f_t    <= {32'd0, r_e_p0} + {r_e_p1, 32'd0};

            r_g_inr  <= r_f_inr;
            r_g_xn   <= r_f_ax.xneg ^ r_f_fneg;
            r_g_yn   <= r_f_ax.yneg ^ r_f_fneg;
            r_g_numx <= {r_f_nx, 48'd0};
            r_g_numy <= {r_f_ny, 48'd0};
            r_g_m0   <= r_f_t[31:0]  * w_mass;
            r_g_m1   <= r_f_t[63:32] * w_mass;
            r_g_m2   <= r_f_t[95:64] * w_mass;

            r_h_inr  <= r_g_inr;
            r_h_xn   <= r_g_xn;
            r_h_yn   <= r_g_yn;
            r_h_numx <= r_g_numx;
            r_h_numy <= r_g_numy;
            r_h_den  <= {64'd0, r_g_m0} + {32'd0, r_g_m1, 32'd0} + {r_g_m2, 64'd0};
        end
    end

    // one divider per axis
    logic                dx_v, dy_v, dx_ovf, dy_ovf;
    logic [DIV_BITS-1:0] dx_q, dy_q;
    t_dtag               dx_tag, dy_tag;
    t_dtag               w_tag_x, w_tag_y;

    assign w_tag_x = {r_h_inr, r_h_xn};
    assign w_tag_y = {r_h_inr, r_h_yn};

    srpf_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_h_v),
        .i_num   (r_h_numx),
        .i_den   (r_h_den),
        .i_tag   (w_tag_x),
        .o_valid (dx_v),
        .o_ovf   (dx_ovf),
        .o_quo   (dx_q),
        .o_tag   (dx_tag)
    );

    srpf_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_h_v),
        .i_num   (r_h_numy),
        .i_den   (r_h_den),
        .i_tag   (w_tag_y),
        .o_valid (dy_v),
        .o_ovf   (dy_ovf),
        .o_quo   (dy_q),
        .o_tag   (dy_tag)
    );

    // sign and saturate one axis; out-of-range pairs give zero
    function automatic logic [W-1:0] sat_axis(input logic inr, input logic neg,
                                               input logic ovf,
                                               input logic [DIV_BITS-1:0] q);
        logic [W-1:0] mag;
        mag = {1'b0, q};
        if (!inr) begin
            return '0;
        end else if (neg) begin
            return ovf ? 32'h8000_0000 : (32'd0 - mag);
        end else begin
            return ovf ? 32'h7FFF_FFFF : mag;
        end
    endfunction

    logic [64:0] w_res;
    assign w_res = {dx_tag.inr,
                    sat_axis(dy_tag.inr, dy_tag.neg, dy_ovf, dy_q),
                    sat_axis(dx_tag.inr, dx_tag.neg, dx_ovf, dx_q)};

    // output register and skid register
    logic [64:0] r_out, r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || i_m_tready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= en && dx_v;
            end
        end else if (en && dx_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || i_m_tready) begin
            r_out <= r_skid_v ? r_skid : w_res;
        end else if (en && dx_v) begin
            r_skid <= w_res;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tuser  = r_out[64];
    assign o_m_tdata  = r_out[63:0];

    // skid only fills behind a waiting output
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid register holds data while output register is empty");

    // both axis dividers stay in lockstep
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dx_v == dy_v) && (!dx_v || (dx_tag.inr == dy_tag.inr)))
        else $error("axis dividers out of step");

    // an out-of-range result carries zero acceleration
    a_zero_out_of_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == 64'd0))
        else $error("nonzero acceleration on an out-of-range pair");

    // a waiting result is not overwritten while the output is stalled
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_m_tready) |=> (r_out_v && $stable(r_out)))
        else $error("output register changed while stalled");

endmodule

// File: tb/tb_short_range_pair_force.sv
// Testbench for the short-range pair force pipeline: directed and random pairs.
module tb_short_range_pair_force;
    timeunit 1ns;
    timeprecision 1ps;
    import srpf_pkg::*;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_idx = '0;
    logic [31:0]  i_cfg_data = '0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [127:0] i_s_tdata = '0;   // own_x, own_y, other_x, other_y
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [63:0]  o_m_tdata;        // accel_x, accel_y
    logic         o_m_tuser;        // in_range

    typedef struct packed {
        logic        in_range;
        logic [31:0] ax;
        logic [31:0] ay;
    } t_force;

    short_range_pair_force DUT (.*);

    always #2 i_clk = ~i_clk;

    // predictor copy of the registers
    logic [31:0] cut_q = 32'd655, min_q = 32'd7, mass_q = 32'd655;

    t_force      force_q[$];
    int          n_err = 0, n_pairs = 0, n_results = 0, n_inrange = 0;
    bit          src_idle = 1'b1, snk_idle = 1'b1;
    int          hold_cycles = 0;
    int          idle_cnt = 0;

    // one axis of the force, exact in 256-bit arithmetic
    function automatic logic [31:0] axis_force(logic [31:0] dmag, logic dneg,
                                               logic [63:0] r, logic [63:0] r2,
                                               logic [63:0] mass, logic [63:0] cut);
        logic         fneg;
        logic [63:0]  fmag;
        logic [255:0] num, den, q;
        if (dmag == 0) return '0;
        fneg = r < cut;
        fmag = fneg ? cut - r : r - cut;
        if (fmag == 0) return '0;
        num = (256'(dmag) * 256'(fmag)) << 48;
        den = 256'(r) * 256'(r2) * 256'(mass);
        q = num / den;
        if (dneg != fneg) begin
            if (q > 256'h8000_0000) q = 256'h8000_0000;
            return 32'(-q[32:0]);
        end
        if (q > 256'h7FFF_FFFF) q = 256'h7FFF_FFFF;
        return q[31:0];
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] res = 0;
        for (int b = 31; b >= 0; b--) begin
            logic [63:0] t;
            t = res | (64'd1 << b);
            if (128'(t) * 128'(t) <= 128'(v)) res = t;
        end
        return res;
    endfunction

    function automatic t_force pair_force(logic [127:0] d);
        logic [31:0] ox, oy, nx, ny, xm, ym;
        logic        xneg, yneg;
        logic [64:0] r2w;
        logic [63:0] r2, cut2, min2, mass, r;
        t_force      f;
        {ny, nx, oy, ox} = d;
        xneg = nx < ox;
        yneg = ny < oy;
        xm = xneg ? ox - nx : nx - ox;
        ym = yneg ? oy - ny : ny - oy;
        r2w = 65'(64'(xm) * xm) + 65'(64'(ym) * ym);
        cut2 = 64'(cut_q) * cut_q;
        min2 = 64'(min_q) * min_q;
        mass = (mass_q == 0) ? 64'd1 : 64'(mass_q);
        f = '0;
        if (r2w[64] || r2w[63:0] > cut2) return f;
        r2 = r2w[63:0];
        if (r2 < min2) r2 = min2;
        if (r2 == 0) r2 = 1;
        r = root_floor(r2);
        f.in_range = 1'b1;
        f.ax = axis_force(xm, xneg, r, r2, mass, 64'(cut_q));
        f.ay = axis_force(ym, yneg, r, r2, mass, 64'(cut_q));
        return f;
    endfunction

    // send one pair, with random gaps unless idling is off
    task automatic send_pair(logic [31:0] ox, oy, nx, ny);
        if (src_idle && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {ny, nx, oy, ox};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        force_q.push_back(pair_force({ny, nx, oy, ox}));
        n_pairs++;
    endtask

    task automatic drain();
        int guard = 0;
        i_s_tvalid <= 1'b0;
        while (force_q.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_CUTOFF: cut_q = v;
            CFG_MIN:    min_q = v;
            default:    mass_q = v;
        endcase
    endtask

    // receiver: random idle bursts, or a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_m_tready <= 1'b0;
        end else if (idle_cnt > 0) begin
            idle_cnt <= idle_cnt - 1;
            i_m_tready <= 1'b0;
        end else if (snk_idle && $urandom_range(0, 7) == 0) begin
            idle_cnt <= $urandom_range(1, 16) - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            t_force exp_f;
            n_results++;
            if (force_q.size() == 0) begin
                $display("%t unexpected result %h/%b", $realtime, o_m_tdata, o_m_tuser);
                n_err++;
            end else begin
                exp_f = force_q.pop_front();
                if (exp_f.in_range) n_inrange++;
                if (o_m_tuser !== exp_f.in_range || o_m_tdata[31:0] !== exp_f.ax ||
                    o_m_tdata[63:32] !== exp_f.ay) begin
                    $display("%t mismatch exp in=%b ax=%h ay=%h got in=%b ax=%h ay=%h",
                             $realtime, exp_f.in_range, exp_f.ax, exp_f.ay,
                             o_m_tuser, o_m_tdata[31:0], o_m_tdata[63:32]);
                    n_err++;
                end
            end
        end
    end

    // random pair near own position, at a spread scaled to the cutoff
    task automatic near_pair(int unsigned spread);
        logic [31:0] ox, oy;
        ox = $urandom;
        oy = $urandom;
        send_pair(ox, oy, ox + $urandom_range(0, 2 * spread) - spread,
                  oy + $urandom_range(0, 2 * spread) - spread);
    endtask

    task automatic test_directed();
        send_pair(0, 0, 0, 0);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF);
        send_pair(100, 100, 100 + 655, 100);
        send_pair(100, 100, 100 + 656, 100);
        send_pair(1000, 1000, 1001, 1000);
        send_pair(1000, 1000, 999, 1000);
        send_pair(1000, 1000, 1000, 1003);
        send_pair(1000, 1000, 1000, 997);
        send_pair(5000, 5000, 5200, 4800);
        send_pair(5000, 5000, 4800, 5200);
        send_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    endtask

    task automatic test_extreme_config();
        write_reg(CFG_MIN, 32'd0);
        write_reg(CFG_MASS, 32'd0);
        send_pair(7, 7, 7, 7);
        send_pair(7, 7, 8, 7);
        write_reg(CFG_MIN, 32'd2000);      // clamp above cutoff: attractive
        write_reg(CFG_MASS, 32'd1);
        send_pair(10, 10, 20, 30);
        send_pair(10, 10, 5, 0);
        write_reg(CFG_CUTOFF, 32'hFFFF_FFFF);
        write_reg(CFG_MIN, 32'hFFFF_FFFF);
        write_reg(CFG_MASS, 32'hFFFF_FFFF);
        send_pair(0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(0, 0, 32'hFFFF_FFFF, 0);
        send_pair(12345, 678, 9, 32'hABCD_0000);
        write_reg(CFG_MIN, 32'd1);
        write_reg(CFG_MASS, 32'd1);
        send_pair(0, 0, 1, 0);
        send_pair(32'h1234_5678, 32'h9ABC_DEF0, 32'h0FED_CBA9, 32'h8765_4321);
    endtask

    // several register settings, mostly in-range pairs with some far ones
    task automatic test_random(int n);
        for (int s = 0; s < 6; s++) begin
            int unsigned c;
            c = (s == 5) ? 32'hFFFF_FFFF :
                (1 << $urandom_range(4, 30)) + $urandom_range(0, 255);
            write_reg(CFG_CUTOFF, c);
            write_reg(CFG_MIN, (s == 0) ? 32'd1 :
                      $urandom_range(0, 1 << $urandom_range(0, 28)));
            write_reg(CFG_MASS, (s == 1) ? 32'hFFFF_FFFF :
                      $urandom_range(1, 1 << $urandom_range(0, 31)));
            for (int k = 0; k < n / 6; k++) begin
                if ($urandom_range(0, 9) < 7)
                    near_pair((c > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : (c < 8 ? 8 : c));
                else
                    send_pair($urandom, $urandom, $urandom, $urandom);
            end
        end
    endtask

    // receiver stops long enough for the pipeline to fill and stall the input
    task automatic test_backpressure();
        write_reg(CFG_CUTOFF, 32'd655);
        hold_cycles = 400;
        for (int k = 0; k < 150; k++) near_pair(700);
    endtask

    task automatic test_no_idle();
        src_idle = 1'b0;
        snk_idle = 1'b0;
        for (int k = 0; k < 200; k++) near_pair(700);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_extreme_config();
        test_random(1200);
        test_backpressure();
        test_no_idle();
        drain();
        $display("Covered %0d pairs, %0d results (%0d in range), extreme and random registers,",
                 n_pairs, n_results, n_inrange);
        $display("random idling on both sides, a long output hold-off and a full-rate stretch.");
        if (n_err == 0 && force_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d errors, %0d results missing", n_err, force_q.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end
endmodule

// File: files.f
design/srpf_pkg.sv
design/srpf_isqrt.sv
design/srpf_div.sv
design/short_range_pair_force.sv
tb/tb_short_range_pair_force.sv
